// ===== hw/rtl/gct_pkg.sv =====
// shared types and constants for the grid line crossing tracer
`default_nettype none
package gct_pkg;
    localparam int CELL_INDEX_BITS_DEF = 5;
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int CFG_W               = 5;
    localparam int CNT_W               = 6;
    localparam int FRAC_W              = 16;
    localparam int Q15_SHIFT           = 15;
    localparam logic [FRAC_W-1:0] Q_ONE = 16'h8000;
    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd31;

    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP_GO,
        ST_GAP_WAIT,
        ST_CELL_GO,
        ST_CELL_WAIT,
        ST_MUL,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_cell;
        logic cap_gap;
        logic cap_cell;
        logic mul;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic one_cell;
        logic div_done;
        logic out_free;
        logic walk_end;
    } t_stat;
endpackage
`default_nettype wire

// ===== hw/rtl/grid_line_crossing_tracer_unit.sv =====
// top level of the grid line crossing tracer
// setup after the accepting edge runs two rounds of the bit-serial dividers, then each
// crossing beat takes a multiply and then a step, which waits for a free output register
// segments are taken one at a time; the next is held off until the walk ends
// a segment whose ends share a cell is accepted while idle and emits nothing
// reset is synchronous active low; it clears control state and the grid width and height registers return to 31
`default_nettype none
module grid_line_crossing_tracer_unit #(
    parameter int CELL_INDEX_BITS = gct_pkg::CELL_INDEX_BITS_DEF,
    parameter int COORD_FRAC_BITS = gct_pkg::COORD_FRAC_BITS_DEF,
    localparam int CW = CELL_INDEX_BITS + COORD_FRAC_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_we,
    input  wire logic [0:0]                i_cfg_idx,
    input  wire logic [gct_pkg::CFG_W-1:0] i_cfg_data,
    // segment channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [CW-1:0]             i_start_x,
    input  wire logic [CW-1:0]             i_start_y,
    input  wire logic [CW-1:0]             i_end_x,
    input  wire logic [CW-1:0]             i_end_y,
    // crossing channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [CELL_INDEX_BITS-1:0]     o_prev_cell_x,
    output logic [CELL_INDEX_BITS-1:0]     o_prev_cell_y,
    output logic [CELL_INDEX_BITS-1:0]     o_next_cell_x,
    output logic [CELL_INDEX_BITS-1:0]     o_next_cell_y,
    output logic [gct_pkg::FRAC_W-1:0]     o_crossing_fraction,
    output logic                           o_last_crossing,
    output logic                           o_truncated
);
    gct_pkg::t_cmd  w_cmd;
    gct_pkg::t_stat w_stat;

    // sequencer: accepts a beat only when idle
    gct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_stat(w_stat), .o_in_stall(o_in_stall), .o_cmd(w_cmd)
    );

    // arithmetic, walk state and the output register
    gct_dpath #(
        .CELL_INDEX_BITS(CELL_INDEX_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid),
        .o_prev_cell_x(o_prev_cell_x), .o_prev_cell_y(o_prev_cell_y),
        .o_next_cell_x(o_next_cell_x), .o_next_cell_y(o_next_cell_y),
        .o_crossing_fraction(o_crossing_fraction),
        .o_last_crossing(o_last_crossing), .o_truncated(o_truncated)
    );

`ifndef SYNTH
    // truncation is only flagged on the final beat
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated) |-> o_last_crossing)
        else $error("truncated beat not marked last");

    // a walk never loads the output register while a held beat is stalled
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_stat.out_free)
        else $error("step into a full output register");

    // a segment spanning cells holds off the next one
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !w_stat.one_cell) |=> o_in_stall)
        else $error("input not stalled during a walk");

    // a crossing fraction never exceeds one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_crossing_fraction <= gct_pkg::Q_ONE))
        else $error("crossing fraction above one");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/gct_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module gct_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quo,
    output logic      [DVS_W-1:0] o_rem
);
    localparam int CW = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_sub;
    logic             w_ge;

    assign w_sh  = {r_rem, r_quo[DVD_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_dvs};
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[DVD_W-2:0], w_ge};
            n_rem = w_ge ? w_sub[DVS_W-1:0] : w_sh[DVS_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== hw/rtl/gct_ctrl.sv =====
// sequencer for segment setup and the crossing walk
`default_nettype none
module gct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire gct_pkg::t_stat i_stat,
    output logic               o_in_stall,
    output gct_pkg::t_cmd      o_cmd
);
    gct_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gct_pkg::ST_IDLE: begin
                if (i_in_valid && !i_stat.one_cell) begin
                    n_state = gct_pkg::ST_GAP_GO;
                end
            end
            gct_pkg::ST_GAP_GO:   n_state = gct_pkg::ST_GAP_WAIT;
            gct_pkg::ST_GAP_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = gct_pkg::ST_CELL_GO;
                end
            end
            gct_pkg::ST_CELL_GO:   n_state = gct_pkg::ST_CELL_WAIT;
            gct_pkg::ST_CELL_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = gct_pkg::ST_MUL;
                end
            end
            gct_pkg::ST_MUL: n_state = gct_pkg::ST_STEP;
            gct_pkg::ST_STEP: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.walk_end ? gct_pkg::ST_IDLE : gct_pkg::ST_MUL;
                end
            end
            default: n_state = gct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            gct_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            gct_pkg::ST_GAP_GO:    o_cmd.div_start = 1'b1;
            gct_pkg::ST_GAP_WAIT:  o_cmd.cap_gap = i_stat.div_done;
            gct_pkg::ST_CELL_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_cell  = 1'b1;
            end
            gct_pkg::ST_CELL_WAIT: o_cmd.cap_cell = i_stat.div_done;
            gct_pkg::ST_MUL:       o_cmd.mul = 1'b1;
            gct_pkg::ST_STEP:      o_cmd.step = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gct_dpath.sv =====
// walk registers, crossing-time arithmetic and output register
`default_nettype none
module gct_dpath #(
    parameter int CELL_INDEX_BITS = gct_pkg::CELL_INDEX_BITS_DEF,
    parameter int COORD_FRAC_BITS = gct_pkg::COORD_FRAC_BITS_DEF,
    localparam int CW = CELL_INDEX_BITS + COORD_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire gct_pkg::t_cmd              i_cmd,
    output gct_pkg::t_stat                  o_stat,
    input  wire logic                       i_cfg_we,
    input  wire logic [0:0]                 i_cfg_idx,
    input  wire logic [gct_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [CW-1:0]              i_start_x,
    input  wire logic [CW-1:0]              i_start_y,
    input  wire logic [CW-1:0]              i_end_x,
    input  wire logic [CW-1:0]              i_end_y,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic [CELL_INDEX_BITS-1:0]      o_prev_cell_x,
    output logic [CELL_INDEX_BITS-1:0]      o_prev_cell_y,
    output logic [CELL_INDEX_BITS-1:0]      o_next_cell_x,
    output logic [CELL_INDEX_BITS-1:0]      o_next_cell_y,
    output logic [gct_pkg::FRAC_W-1:0]      o_crossing_fraction,
    output logic                            o_last_crossing,
    output logic                            o_truncated
);
    localparam int CIB   = CELL_INDEX_BITS;
    localparam int CFB   = COORD_FRAC_BITS;
    localparam int NT_W  = CFB + 7;
    localparam int Q_W   = NT_W + gct_pkg::Q15_SHIFT;
    localparam int GAP_W = CFB + 1;
    localparam int DVD_W = GAP_W + gct_pkg::Q15_SHIFT;
    localparam int P_W   = NT_W + CW;
    localparam int CNT_W = gct_pkg::CNT_W;

    logic [gct_pkg::CFG_W-1:0] r_gw, r_gh;
    logic [CIB-1:0] r_cx, r_cy, r_tx, r_ty;
    logic           r_xnz, r_xneg, r_ynz, r_yneg;
    logic [CW-1:0]  r_stx, r_sty, r_rx, r_ry, r_drx, r_dry;
    logic [GAP_W-1:0] r_gapx, r_gapy;
    logic [NT_W-1:0] r_ntx, r_nty;
    logic [Q_W-1:0]  r_qx, r_qy, r_dqx, r_dqy;
    logic [P_W-1:0]  r_lx, r_ly;
    logic [CNT_W-1:0] r_cnt;
    logic r_out_valid;
    logic [CIB-1:0] r_opx, r_opy, r_onx, r_ony;
    logic [gct_pkg::FRAC_W-1:0] r_ofr;
    logic r_olast, r_otrunc;

    // setup from the accepted beat
    logic w_xpos, w_xneg, w_ypos, w_yneg;
    logic [CW-1:0] w_stx, w_sty;
    logic [GAP_W-1:0] w_gapx, w_gapy;
    logic [CFB-1:0] w_fx, w_fy;

    assign w_xpos = i_end_x > i_start_x;
    assign w_xneg = i_end_x < i_start_x;
    assign w_ypos = i_end_y > i_start_y;
    assign w_yneg = i_end_y < i_start_y;
    assign w_stx  = w_xpos ? i_end_x - i_start_x : i_start_x - i_end_x;
    assign w_sty  = w_ypos ? i_end_y - i_start_y : i_start_y - i_end_y;
    assign w_fx   = i_start_x[CFB-1:0];
    assign w_fy   = i_start_y[CFB-1:0];
    assign w_gapx = w_xpos ? (GAP_W'(1) << CFB) - {1'b0, w_fx} : {1'b0, w_fx};
    assign w_gapy = w_ypos ? (GAP_W'(1) << CFB) - {1'b0, w_fy} : {1'b0, w_fy};

    // dividers for start fraction and per-cell fraction increment
    logic [DVD_W-1:0] w_dvd_x, w_dvd_y, w_quo_x, w_quo_y;
    logic [CW-1:0]    w_rem_x, w_rem_y;
    logic             w_done_x, w_done_y;

    assign w_dvd_x = i_cmd.div_cell ? DVD_W'(1) << (CFB + gct_pkg::Q15_SHIFT)
                                    : {r_gapx, {gct_pkg::Q15_SHIFT{1'b0}}};
    assign w_dvd_y = i_cmd.div_cell ? DVD_W'(1) << (CFB + gct_pkg::Q15_SHIFT)
                                    : {r_gapy, {gct_pkg::Q15_SHIFT{1'b0}}};

    gct_div #(.DVD_W(DVD_W), .DVS_W(CW)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(w_dvd_x), .i_divisor(r_stx),
        .o_done(w_done_x), .o_quo(w_quo_x), .o_rem(w_rem_x)
    );
    gct_div #(.DVD_W(DVD_W), .DVS_W(CW)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(w_dvd_y), .i_divisor(r_sty),
        .o_done(w_done_y), .o_quo(w_quo_y), .o_rem(w_rem_y)
    );

    // one crossing
    logic w_both, w_mvx, w_mvy, w_ystep, w_done, w_trunc, w_wx, w_wy;
    logic [CIB-1:0] w_ncx, w_ncy;
    logic [gct_pkg::FRAC_W-1:0] w_frx, w_fry;
    logic [CW:0] w_srx, w_sry;
    logic [CNT_W-1:0] w_cnt, w_limit;

    assign w_both  = r_xnz && r_ynz;
    assign w_mvx   = w_both ? (r_lx <= r_ly) : r_xnz;
    assign w_mvy   = w_both ? (r_ly <= r_lx) : !r_xnz;
    assign w_ystep = w_mvy && r_ynz;
    assign w_frx   = (r_ntx >= NT_W'(r_stx)) ? gct_pkg::Q_ONE : r_qx[gct_pkg::FRAC_W-1:0];
    assign w_fry   = (r_nty >= NT_W'(r_sty)) ? gct_pkg::Q_ONE : r_qy[gct_pkg::FRAC_W-1:0];
    assign w_ncx   = w_mvx ? r_cx + (r_xneg ? {CIB{1'b1}} : CIB'(1)) : r_cx;
    assign w_ncy   = w_ystep ? r_cy + (r_yneg ? {CIB{1'b1}} : CIB'(1)) : r_cy;
    assign w_srx   = {1'b0, r_rx} + {1'b0, r_drx};
    assign w_sry   = {1'b0, r_ry} + {1'b0, r_dry};
    assign w_wx    = w_srx >= {1'b0, r_stx};
    assign w_wy    = w_sry >= {1'b0, r_sty};
    assign w_cnt   = r_cnt + 1'b1;
    assign w_limit = CNT_W'(r_gw) + CNT_W'(r_gh) + CNT_W'(1);
    assign w_done  = (w_ncx == r_tx) && (w_ncy == r_ty);
    assign w_trunc = !w_done && (w_cnt >= w_limit);

    assign o_stat.one_cell  = (i_start_x[CW-1:CFB] == i_end_x[CW-1:CFB]) &&
                              (i_start_y[CW-1:CFB] == i_end_y[CW-1:CFB]);
    assign o_stat.div_done  = w_done_x && w_done_y;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.walk_end  = w_done || w_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw        <= gct_pkg::CFG_RESET;
            r_gh        <= gct_pkg::CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == gct_pkg::CFG_GRID_WIDTH) begin
                r_gw <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == gct_pkg::CFG_GRID_HEIGHT) begin
                r_gh <= i_cfg_data;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.load) begin
            r_cx   <= i_start_x[CW-1:CFB];
            r_cy   <= i_start_y[CW-1:CFB];
            r_tx   <= i_end_x[CW-1:CFB];
            r_ty   <= i_end_y[CW-1:CFB];
            r_xnz  <= w_xpos || w_xneg;
            r_xneg <= w_xneg;
            r_ynz  <= w_ypos || w_yneg;
            r_yneg <= w_yneg;
            r_stx  <= w_stx;
            r_sty  <= w_sty;
            r_gapx <= w_gapx;
            r_gapy <= w_gapy;
            r_ntx  <= NT_W'(w_gapx);
            r_nty  <= NT_W'(w_gapy);
            r_cnt  <= '0;
        end
        if (i_cmd.cap_gap) begin
            r_qx <= Q_W'(w_quo_x);
            r_qy <= Q_W'(w_quo_y);
            r_rx <= w_rem_x;
            r_ry <= w_rem_y;
        end
        if (i_cmd.cap_cell) begin
            r_dqx <= Q_W'(w_quo_x);
            r_dqy <= Q_W'(w_quo_y);
            r_drx <= w_rem_x;
            r_dry <= w_rem_y;
        end
        if (i_cmd.mul) begin
            r_lx <= P_W'(r_ntx) * P_W'(r_sty);
            r_ly <= P_W'(r_nty) * P_W'(r_stx);
        end
        if (i_cmd.step) begin
            r_opx    <= r_cx;
            r_opy    <= r_cy;
            r_onx    <= w_ncx;
            r_ony    <= w_ncy;
            r_ofr    <= w_mvx ? w_frx : w_fry;
            r_olast  <= w_done || w_trunc;
            r_otrunc <= w_trunc;
            r_cx     <= w_ncx;
            r_cy     <= w_ncy;
            r_cnt    <= w_cnt;
            if (w_mvx) begin
                r_ntx <= r_ntx + (NT_W'(1) << CFB);
                r_qx  <= r_qx + r_dqx + Q_W'(w_wx);
                r_rx  <= w_wx ? CW'(w_srx - {1'b0, r_stx}) : w_srx[CW-1:0];
            end
            if (w_ystep) begin
                r_nty <= r_nty + (NT_W'(1) << CFB);
                r_qy  <= r_qy + r_dqy + Q_W'(w_wy);
                r_ry  <= w_wy ? CW'(w_sry - {1'b0, r_sty}) : w_sry[CW-1:0];
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_prev_cell_x       = r_opx;
    assign o_prev_cell_y       = r_opy;
    assign o_next_cell_x       = r_onx;
    assign o_next_cell_y       = r_ony;
    assign o_crossing_fraction = r_ofr;
    assign o_last_crossing     = r_olast;
    assign o_truncated         = r_otrunc;
endmodule
`default_nettype wire
